/* rtl/sli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants for the sequential list insert/remove block.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int IDX_W   = 13;  // list index, covers capacities up to 8191
  localparam int FANIN   = 8;   // fan-in of each readout tree node
  localparam int CMD_W   = 3;
  localparam int POS_W   = 10;
  localparam int EVAL_W  = 16;
  localparam int STAT_W  = 2;
  localparam int CNTO_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_POS   = 3'd0,
    CMD_INS_FRONT = 3'd1,
    CMD_INS_END   = 3'd2,
    CMD_REM_POS   = 3'd3,
    CMD_REM_FRONT = 3'd4,
    CMD_REM_END   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // broadcast to every cell for one cycle per committed command
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
  } sli_op_t;

  // register levels of the readout tree for n leaves
  function automatic int tree_levels(input int n);
    int l;
    int m;
    l = 1;
    m = n;
    while (m > FANIN) begin
      m = (m + FANIN - 1) / FANIN;
      l++;
    end
    return l;
  endfunction

endpackage

/* rtl/sli_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_cell
// One list slot: holds an entry and shifts with its neighbors on a command.
// ----------------------------------------------------------------------------
module sli_cell import sli_pkg::*; #(
  parameter int IDX = 0,
  parameter int W   = 16
) (
  input  logic          clk,
  input  sli_op_t       op,
  input  logic [W-1:0]  new_value,
  input  logic [W-1:0]  left_value,
  input  logic [W-1:0]  right_value,
  output logic [W-1:0]  value,
  output logic [W-1:0]  tap
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic at_pos;
  logic past_pos;

  assign at_pos   = (MY_IDX == op.pos);
  assign past_pos = (MY_IDX > op.pos);

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (past_pos) begin
        value <= left_value;
      end else if (at_pos) begin
        value <= new_value;
      end
    end else if (op.rem && (past_pos || at_pos)) begin
      value <= right_value;
    end
  end

  assign tap = (op.rem && at_pos) ? value : '0;

endmodule

/* rtl/sli_or_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_or_tree
// Registered OR reduction of the cell taps, FANIN leaves per node per level.
// ----------------------------------------------------------------------------
module sli_or_tree import sli_pkg::*; #(
  parameter int N = 8,
  parameter int W = 16
) (
  input  logic                 clk,
  input  logic [N-1:0][W-1:0]  in_data,
  output logic [W-1:0]         out_data
);

  localparam int NG = (N + FANIN - 1) / FANIN;

  logic [NG-1:0][W-1:0] grp_q;

  for (genvar g = 0; g < NG; g++) begin : g_grp
    localparam int LO  = g * FANIN;
    localparam int CNT = ((N - LO) < FANIN) ? (N - LO) : FANIN;
    logic [W-1:0] acc;

    always_comb begin
      acc = '0;
      for (int k = 0; k < CNT; k++) begin
        acc = acc | in_data[LO + k];
      end
    end

    always_ff @(posedge clk) begin
      grp_q[g] <= acc;
    end
  end

  if (NG == 1) begin : g_root
    assign out_data = grp_q[0];
  end else begin : g_next
    sli_or_tree #(.N(NG), .W(W)) u_next (
      .clk      (clk),
      .in_data  (grp_q),
      .out_data (out_data)
    );
  end

endmodule

/* rtl/sequential_list_insert_remove.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_insert_remove
// Ordered list of entry handles with insert/remove at position, front or end.
//
// Command channel (cmd_valid/cmd_stall): one beat carries cmd, position and
// entry_value. Response channel (rsp_valid/rsp_stall): one beat per command
// carries status, removed_value and count_after.
// The list lives in a row of CAPACITY cells; a committed command shifts the
// cells at and past its position in the cycle it is accepted. A removed entry
// is read back through a registered OR tree of LAT = ceil(log8(CAPACITY))
// levels (4 at 1024), captured in hold_removed at the end of S_WAIT and
// moved to the output register from S_DONE. One command is in flight at a
// time; no new command is taken until the last one has left S_DONE.
// A finished response waits in the output register while the next command
// is taken; if rsp_stall holds the previous response, the new one parks in
// a holding register and cmd_stall stays high until it can move out.
// Failed commands report a status code and leave the list unchanged.
// Reset (rst, synchronous) empties the list, holds cmd_stall high and drops
// any pending response; cell contents are not cleared, only read below count.
// ----------------------------------------------------------------------------
module sequential_list_insert_remove import sli_pkg::*; #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [POS_W-1:0]  position,
  input  logic [EVAL_W-1:0] entry_value,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [STAT_W-1:0] status,
  output logic [EVAL_W-1:0] removed_value,
  output logic [CNTO_W-1:0] count_after
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LAT    = tree_levels(CAPACITY);
  localparam int WAIT_W = $clog2(LAT + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [WAIT_W-1:0]       wait_cnt;
  logic [STAT_W-1:0]       pend_status;
  logic [CNTO_W-1:0]       pend_count;
  logic [VALUE_BITS-1:0]   hold_removed;

  logic                    accept;
  logic [IDX_W-1:0]        cnt_ext;
  logic [IDX_W-1:0]        pos_ext;
  logic [IDX_W-1:0]        eff_pos;
  logic                    is_ins;
  logic                    is_rem;
  status_t                 st;
  sli_op_t                 op;
  logic [VALUE_BITS-1:0]   new_value;
  logic [VALUE_BITS-1:0]   tree_out;
  logic                    rsp_free;

  logic [CAPACITY-1:0][VALUE_BITS-1:0] cell_value;
  logic [CAPACITY-1:0][VALUE_BITS-1:0] cell_tap;

  assign cmd_stall = rst || (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign cnt_ext   = IDX_W'(count);
  assign pos_ext   = IDX_W'(position);
  assign new_value = VALUE_BITS'(entry_value);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    eff_pos = '0;
    unique case (cmd)
      CMD_INS_POS: begin
        is_ins  = 1'b1;
        eff_pos = pos_ext;
      end
      CMD_INS_FRONT: begin
        is_ins  = 1'b1;
      end
      CMD_INS_END: begin
        is_ins  = 1'b1;
        eff_pos = cnt_ext;
      end
      CMD_REM_POS: begin
        is_rem  = 1'b1;
        eff_pos = pos_ext;
      end
      CMD_REM_FRONT: begin
        is_rem  = 1'b1;
      end
      CMD_REM_END: begin
        is_rem  = 1'b1;
        eff_pos = cnt_ext - IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st = ST_OK;
    if (is_ins) begin
      if (eff_pos > cnt_ext) begin
        st = ST_BADPOS;
      end else if (cnt_ext == IDX_W'(CAPACITY)) begin
        st = ST_FULL;
      end
    end else if (is_rem) begin
      if (count == '0) begin
        st = ST_EMPTY;
      end else if (eff_pos >= cnt_ext) begin
        st = ST_BADPOS;
      end
    end
  end

  always_comb begin
    op.ins = accept && is_ins && (st == ST_OK);
    op.rem = accept && is_rem && (st == ST_OK);
    op.pos = eff_pos;
    count_next = count;
    if (op.ins) begin
      count_next = count + CNT_W'(1);
    end else if (op.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v;
    logic [VALUE_BITS-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = new_value;
    end else begin : g_left
      assign left_v = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_value[i+1];
    end

    sli_cell #(.IDX(i), .W(VALUE_BITS)) u_cell (
      .clk         (clk),
      .op          (op),
      .new_value   (new_value),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[i]),
      .tap         (cell_tap[i])
    );
  end

  sli_or_tree #(.N(CAPACITY), .W(VALUE_BITS)) u_tree (
    .clk      (clk),
    .in_data  (cell_tap),
    .out_data (tree_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      wait_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            wait_cnt <= WAIT_W'(LAT - 1);
            state    <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (wait_cnt == '0) begin
            state <= S_DONE;
          end else begin
            wait_cnt <= wait_cnt - WAIT_W'(1);
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= st;
      pend_count  <= CNTO_W'(count_next);
    end
    if (state == S_WAIT && wait_cnt == '0) begin
      hold_removed <= tree_out;
    end
    if (state == S_DONE && rsp_free) begin
      status        <= pend_status;
      removed_value <= EVAL_W'(hold_removed);
      count_after   <= pend_count;
    end
  end

endmodule
